// ===== rtl/core/clip_rectangle_stack_macros.svh =====
// Assertion macros for the clip rectangle stack.
// Used by crs_store, the RTL file that carries concurrent assertions; needs no package.
`ifndef CLIP_RECTANGLE_STACK_MACROS_SVH
`define CLIP_RECTANGLE_STACK_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CRS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("clip_rectangle_stack: same-cycle check failed");
`define CRS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("clip_rectangle_stack: next-cycle check failed");
`else
`define CRS_ASSERT_SAME(label, ante, cons)
`define CRS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/crs_pkg.sv =====
// Shared types, codes and constants of the clip rectangle stack.
// No dependencies; every other RTL file but the assertion macros uses it.
package crs_pkg;

   localparam int unsigned COORD_W             = 16;
   localparam int unsigned DEPTH_W             = 4;
   localparam int unsigned STACK_DEPTH_DEFAULT = 8;

   typedef enum logic [1:0] {
      MODE_PUSH = 2'd0,
      MODE_POP  = 2'd1,
      MODE_JOIN = 2'd2,
      MODE_CUT  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } error_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] w;
      logic signed [COORD_W-1:0] h;
      logic                      set;
   } rect_type;

   typedef struct packed {
      logic     valid;
      mode_type mode;
      rect_type op;
   } cmd_type;

   typedef struct packed {
      rect_type            top;
      logic [DEPTH_W-1:0]  depth;
      error_type           error;
   } result_type;

endpackage

// ===== rtl/core/crs_if.sv =====
// Handshake interfaces of the clip rectangle stack: command and response channels.
// Depends on crs_pkg for field widths.
interface crs_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         mode;
   logic signed [crs_pkg::COORD_W-1:0] rect_x;
   logic signed [crs_pkg::COORD_W-1:0] rect_y;
   logic signed [crs_pkg::COORD_W-1:0] rect_width;
   logic signed [crs_pkg::COORD_W-1:0] rect_height;
   logic                               rect_valid;

   modport source (output valid, mode, rect_x, rect_y, rect_width, rect_height, rect_valid,
                   input ready);
   modport sink   (input valid, mode, rect_x, rect_y, rect_width, rect_height, rect_valid,
                   output ready);
endinterface

interface crs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [crs_pkg::COORD_W-1:0] top_x;
   logic signed [crs_pkg::COORD_W-1:0] top_y;
   logic signed [crs_pkg::COORD_W-1:0] top_width;
   logic signed [crs_pkg::COORD_W-1:0] top_height;
   logic                               top_valid;
   logic [crs_pkg::DEPTH_W-1:0]        depth;
   logic [1:0]                         error;

   modport source (output valid, top_x, top_y, top_width, top_height, top_valid, depth, error,
                   input ready);
   modport sink   (input valid, top_x, top_y, top_width, top_height, top_valid, depth, error,
                   output ready);
endinterface

// ===== rtl/core/crs_geom.sv =====
// Rectangle arithmetic: intersection and bounding box of the top clip and the operand.
// Depends on crs_pkg for rect_type.
module crs_geom (
   input  crs_pkg::rect_type top,
   input  crs_pkg::rect_type op,
   output crs_pkg::rect_type cut,
   output crs_pkg::rect_type join_box
);
   import crs_pkg::*;

   logic signed [COORD_W:0] tx, ty, tx2, ty2;
   logic signed [COORD_W:0] ox, oy, ox2, oy2;
   logic signed [COORD_W:0] cx, cy, cx2, cy2;
   logic signed [COORD_W:0] jx, jy, jx2, jy2;
   logic                    overlap;

   always_comb begin
      tx  = (COORD_W+1)'(top.x);
      ty  = (COORD_W+1)'(top.y);
      tx2 = tx + (COORD_W+1)'(top.w);
      ty2 = ty + (COORD_W+1)'(top.h);
      ox  = (COORD_W+1)'(op.x);
      oy  = (COORD_W+1)'(op.y);
      ox2 = ox + (COORD_W+1)'(op.w);
      oy2 = oy + (COORD_W+1)'(op.h);

      overlap = (ox <= tx2) && (ox2 >= tx) && (oy <= ty2) && (oy2 >= ty);

      cx  = (tx < ox) ? ox : tx;
      cy  = (ty < oy) ? oy : ty;
      cx2 = (tx2 > ox2) ? ox2 : tx2;
      cy2 = (ty2 > oy2) ? oy2 : ty2;

      jx  = (tx > ox) ? ox : tx;
      jy  = (ty > oy) ? oy : ty;
      jx2 = (tx2 < ox2) ? ox2 : tx2;
      jy2 = (ty2 < oy2) ? oy2 : ty2;

      if (!top.set) begin
         cut = op;
      end else if (!op.set) begin
         cut = top;
      end else if (!overlap) begin
         cut = '0;
      end else begin
         cut.x   = cx[COORD_W-1:0];
         cut.y   = cy[COORD_W-1:0];
         cut.w   = COORD_W'(cx2 - cx);
         cut.h   = COORD_W'(cy2 - cy);
         cut.set = 1'b1;
      end

      if (!top.set || !op.set) begin
         join_box = '0;
      end else begin
         join_box.x   = jx[COORD_W-1:0];
         join_box.y   = jy[COORD_W-1:0];
         join_box.w   = COORD_W'(jx2 - jx);
         join_box.h   = COORD_W'(jy2 - jy);
         join_box.set = 1'b1;
      end
   end

endmodule

// ===== rtl/core/crs_store.sv =====
// Stack state: entry count, cached top and next-below entries, memory of older entries.
// Depends on crs_pkg, crs_geom and the assertion macros.
`include "clip_rectangle_stack_macros.svh"
module crs_store #(
   parameter int unsigned STACK_DEPTH = crs_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  crs_pkg::cmd_type     cmd,
   output crs_pkg::result_type  result
);
   import crs_pkg::*;

   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [CW-1:0] count_ff, count_in;
   rect_type      top_ff, top_in;
   rect_type      below_ff;
   rect_type      mem [STACK_DEPTH];

   rect_type      op;
   rect_type      cut;
   rect_type      join_box;
   logic          empty;
   logic          full;
   logic          mem_we;
   logic          mem_re;
   logic [CW-1:0] wr_idx;
   logic [CW-1:0] rd_idx;
   error_type     error;
   logic          push_ok;
   logic          pop_ok;

   assign op     = cmd.op.set ? cmd.op : '0;
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CW'(STACK_DEPTH));
   assign wr_idx = count_ff - CW'(1);
   assign rd_idx = count_ff - CW'(3);

   crs_geom u_geom (
      .top      (top_ff),
      .op       (op),
      .cut      (cut),
      .join_box (join_box)
   );

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      error    = ERR_NONE;
      if (cmd.valid) begin
         unique case (cmd.mode)
            MODE_PUSH: begin
               if (full) begin
                  error = ERR_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
                  top_in   = empty ? op : cut;
                  mem_we   = !empty;
               end
            end
            MODE_POP: begin
               if (empty) begin
                  error = ERR_EMPTY;
               end else begin
                  count_in = count_ff - CW'(1);
                  top_in   = below_ff;
                  mem_re   = 1'b1;
               end
            end
            MODE_JOIN: begin
               if (empty) begin
                  error = ERR_EMPTY;
               end else begin
                  top_in = join_box;
               end
            end
            MODE_CUT: begin
               if (empty) begin
                  error = ERR_EMPTY;
               end else begin
                  top_in = cut;
               end
            end
            default: begin
               error = ERR_NONE;
            end
         endcase
      end
   end

   always_comb begin
      result.top   = (count_in == '0) ? '0 : top_in;
      result.depth = DEPTH_W'(count_in);
      result.error = error;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (mem_we) begin
         mem[wr_idx[AW-1:0]] <= top_ff;
      end
      if (mem_we) begin
         below_ff <= top_ff;
      end else if (mem_re) begin
         below_ff <= mem[rd_idx[AW-1:0]];
      end
   end

   assign push_ok = !reset && cmd.valid && (cmd.mode == MODE_PUSH) && !full;
   assign pop_ok  = !reset && cmd.valid && (cmd.mode == MODE_POP) && (count_ff > CW'(1));

   `CRS_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CW'(STACK_DEPTH))
   `CRS_ASSERT_NEXT(a_push_grows, push_ok, count_ff == $past(count_ff) + CW'(1))
   `CRS_ASSERT_NEXT(a_pop_restores, pop_ok, top_ff == $past(below_ff))
   `CRS_ASSERT_SAME(a_empty_flags, cmd.valid && empty && (cmd.mode != MODE_PUSH), result.error == ERR_EMPTY)

endmodule

// ===== rtl/core/clip_rectangle_stack.sv =====
// Clip rectangle stack top level: command register, stack state, response register.
// Depends on crs_pkg, crs_if and crs_store.
//
// Usage:
//   req_ch carries one command per transaction: mode (push, pop, join into top,
//   intersect top) and an operand rectangle x, y, width, height with a set bit.
//   rsp_ch returns exactly one transaction per command: the top clip after the
//   command, the stack depth and an error code (empty stack, full on push).
//   A command is held in an input register; when it advances it updates the stack
//   and its response is loaded into the output register, so the response is
//   offered from the output register once the command has left the input register.
//   One command is taken per cycle while
//   the receiver keeps up; the rate is set by the single update of the cached
//   top entry, which needs the previous command's result.
//   Older entries live in a memory with one write and one registered read per
//   cycle; the entry under the top is kept in a register so a pop costs no stall.
//   Reset empties the stack and drops any command or response in flight.
//   When the receiver stalls, the response holds and one more command may wait
//   in the input register; req_ch.ready then falls until the response is taken.
module clip_rectangle_stack #(
   parameter int unsigned STACK_DEPTH = crs_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   crs_req_if.sink   req_ch,
   crs_rsp_if.source rsp_ch
);
   import crs_pkg::*;

   logic       in_valid_ff;
   cmd_type    in_cmd_ff;
   logic       out_valid_ff;
   result_type out_ff;
   cmd_type    cmd;
   result_type result;
   logic       advance;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_cmd_ff.valid  <= 1'b1;
         in_cmd_ff.mode   <= mode_type'(req_ch.mode);
         in_cmd_ff.op.x   <= req_ch.rect_x;
         in_cmd_ff.op.y   <= req_ch.rect_y;
         in_cmd_ff.op.w   <= req_ch.rect_width;
         in_cmd_ff.op.h   <= req_ch.rect_height;
         in_cmd_ff.op.set <= req_ch.rect_valid;
      end
   end

   always_comb begin
      cmd       = in_cmd_ff;
      cmd.valid = advance;
   end

   crs_store #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.top_x      = out_ff.top.x;
   assign rsp_ch.top_y      = out_ff.top.y;
   assign rsp_ch.top_width  = out_ff.top.w;
   assign rsp_ch.top_height = out_ff.top.h;
   assign rsp_ch.top_valid  = out_ff.top.set;
   assign rsp_ch.depth      = out_ff.depth;
   assign rsp_ch.error      = out_ff.error;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for clip_rectangle_stack: directed and random commands
// through a clocked driver and monitor, checked against an in-bench stack predictor.
// Depends on crs_pkg, crs_if and the clip_rectangle_stack RTL.
`timescale 1ns / 1ps

module tb;
   import crs_pkg::*;

   localparam int unsigned STACK_DEPTH  = 8;
   localparam int          RANDOM_CMDS  = 1150;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          HOLD_CYCLES  = 200;
   localparam int          DRAIN_CYCLES = 10;

   typedef struct packed {
      mode_type mode;
      rect_type op;
   } clip_cmd_type;

   logic clock;
   logic reset = 1'b1;

   crs_req_if req_ch ();
   crs_rsp_if rsp_ch ();

   clip_rectangle_stack #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   clip_cmd_type pending_cmds[$];
   result_type   tops_due[$];
   rect_type     clip_model[STACK_DEPTH];
   int unsigned  model_fill = 0;
   int           cmds_queued = 0;
   int           cmds_taken = 0;
   int           tops_seen = 0;
   int           mismatches = 0;
   int           cycle_count = 0;
   int           gen_fill = 0;

   initial begin
      clock = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.mode = '0;
      req_ch.rect_x = '0;
      req_ch.rect_y = '0;
      req_ch.rect_width = '0;
      req_ch.rect_height = '0;
      req_ch.rect_valid = 1'b0;
      rsp_ch.ready = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int widen(logic signed [COORD_W-1:0] v);
      return int'(v);
   endfunction

   function automatic rect_type cut_rect(rect_type a, rect_type b);
      int ax2, ay2, bx2, by2, nx, ny, nx2, ny2;
      rect_type r;
      if (!a.set) return b;
      if (!b.set) return a;
      ax2 = widen(a.x) + widen(a.w);
      ay2 = widen(a.y) + widen(a.h);
      bx2 = widen(b.x) + widen(b.w);
      by2 = widen(b.y) + widen(b.h);
      if (!(widen(b.x) <= ax2 && bx2 >= widen(a.x) &&
            widen(b.y) <= ay2 && by2 >= widen(a.y)))
         return '0;
      nx  = (widen(a.x) < widen(b.x)) ? widen(b.x) : widen(a.x);
      ny  = (widen(a.y) < widen(b.y)) ? widen(b.y) : widen(a.y);
      nx2 = (ax2 > bx2) ? bx2 : ax2;
      ny2 = (ay2 > by2) ? by2 : ay2;
      r.x = COORD_W'(nx);
      r.y = COORD_W'(ny);
      r.w = COORD_W'(nx2 - nx);
      r.h = COORD_W'(ny2 - ny);
      r.set = 1'b1;
      return r;
   endfunction

   function automatic rect_type join_rect(rect_type a, rect_type b);
      int ax2, ay2, bx2, by2, nx, ny, nx2, ny2;
      rect_type r;
      if (!a.set || !b.set) return '0;
      ax2 = widen(a.x) + widen(a.w);
      ay2 = widen(a.y) + widen(a.h);
      bx2 = widen(b.x) + widen(b.w);
      by2 = widen(b.y) + widen(b.h);
      nx  = (widen(a.x) > widen(b.x)) ? widen(b.x) : widen(a.x);
      ny  = (widen(a.y) > widen(b.y)) ? widen(b.y) : widen(a.y);
      nx2 = (ax2 < bx2) ? bx2 : ax2;
      ny2 = (ay2 < by2) ? by2 : ay2;
      r.x = COORD_W'(nx);
      r.y = COORD_W'(ny);
      r.w = COORD_W'(nx2 - nx);
      r.h = COORD_W'(ny2 - ny);
      r.set = 1'b1;
      return r;
   endfunction

   function automatic void apply_clip_command(clip_cmd_type cmd);
      rect_type   op;
      rect_type   top;
      result_type res;
      op = cmd.op.set ? cmd.op : rect_type'('0);
      res.error = ERR_NONE;
      if (cmd.mode == MODE_PUSH) begin
         if (model_fill >= STACK_DEPTH) begin
            res.error = ERR_FULL;
         end else begin
            clip_model[model_fill] = (model_fill > 0) ?
                                     cut_rect(clip_model[model_fill-1], op) : op;
            model_fill++;
         end
      end else if (model_fill == 0) begin
         res.error = ERR_EMPTY;
      end else if (cmd.mode == MODE_POP) begin
         model_fill--;
      end else if (cmd.mode == MODE_JOIN) begin
         clip_model[model_fill-1] = join_rect(clip_model[model_fill-1], op);
      end else begin
         clip_model[model_fill-1] = cut_rect(clip_model[model_fill-1], op);
      end
      top = (model_fill > 0) ? clip_model[model_fill-1] : rect_type'('0);
      if (!top.set) top = '0;
      res.top = top;
      res.depth = DEPTH_W'(model_fill);
      tops_due = {tops_due, res};
   endfunction

   function automatic void check_field(string what, logic [COORD_W-1:0] expv,
                                       logic [COORD_W-1:0] actv);
      if (actv !== expv) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, expv, actv);
      end
   endfunction

   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 60);
      return $urandom_range(0, 4);
   endfunction

   // driver
   clip_cmd_type cmd_on_bus;
   int           send_gap = 0;
   int           send_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_clip_command(cmd_on_bus);
            cmds_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0 || pending_cmds.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_ch.valid <= 1'b0;
            end else begin
               cmd_on_bus = pending_cmds.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.mode        <= cmd_on_bus.mode;
               req_ch.rect_x      <= cmd_on_bus.op.x;
               req_ch.rect_y      <= cmd_on_bus.op.y;
               req_ch.rect_width  <= cmd_on_bus.op.w;
               req_ch.rect_height <= cmd_on_bus.op.h;
               req_ch.rect_valid  <= cmd_on_bus.op.set;
               send_gap = draw_gap(send_calm);
            end
         end
      end
   end

   // monitor
   result_type want;
   int         recv_gap = 0;
   int         recv_calm = 0;
   int         hold_left = 0;
   int         holds_done = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            tops_seen++;
            if (tops_due.size() == 0) begin
               mismatches++;
               $display("%0t: response with no command pending, actual depth %0d error %0d",
                        $time, rsp_ch.depth, rsp_ch.error);
            end else begin
               want = tops_due.pop_front();
               check_field("top_x", want.top.x, rsp_ch.top_x);
               check_field("top_y", want.top.y, rsp_ch.top_y);
               check_field("top_width", want.top.w, rsp_ch.top_width);
               check_field("top_height", want.top.h, rsp_ch.top_height);
               check_field("top_valid", COORD_W'(want.top.set), COORD_W'(rsp_ch.top_valid));
               check_field("depth", COORD_W'(want.depth), COORD_W'(rsp_ch.depth));
               check_field("error", COORD_W'(want.error), COORD_W'(rsp_ch.error));
            end
            recv_gap = draw_gap(recv_calm);
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // long receiver stall
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if ((holds_done == 0 && tops_seen >= 300) ||
                   (holds_done == 1 && tops_seen >= 800)) begin
         hold_left <= HOLD_CYCLES;
         holds_done++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   task automatic add_cmd(mode_type m, int x, int y, int w, int h, bit set);
      clip_cmd_type c;
      c.mode = m;
      c.op.x = COORD_W'(x);
      c.op.y = COORD_W'(y);
      c.op.w = COORD_W'(w);
      c.op.h = COORD_W'(h);
      c.op.set = set;
      pending_cmds = {pending_cmds, c};
      cmds_queued++;
      if (m == MODE_PUSH && gen_fill < STACK_DEPTH) gen_fill++;
      if (m == MODE_POP && gen_fill > 0) gen_fill--;
   endtask

   function automatic int pick_coord(bit is_span);
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
         return is_span ? $urandom_range(0, 90) - 10 : $urandom_range(0, 160) - 80;
      end else if (kind < 7) begin
         case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
         endcase
      end
      return $urandom_range(0, 65535) - 32768;
   endfunction

   task automatic add_random_cmd();
      mode_type m;
      int       roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         m = mode_type'($urandom_range(0, 3));
      end else if (gen_fill == 0) begin
         m = (roll < 90) ? MODE_PUSH : mode_type'($urandom_range(1, 3));
      end else if (gen_fill == STACK_DEPTH) begin
         m = (roll < 25) ? MODE_PUSH : mode_type'($urandom_range(1, 3));
      end else if (roll < 42) begin
         m = MODE_PUSH;
      end else if (roll < 64) begin
         m = MODE_POP;
      end else if (roll < 82) begin
         m = MODE_JOIN;
      end else begin
         m = MODE_CUT;
      end
      add_cmd(m, pick_coord(0), pick_coord(0), pick_coord(1), pick_coord(1),
              $urandom_range(0, 99) < 85);
   endtask

   initial begin
      // empty stack
      add_cmd(MODE_POP, 0, 0, 0, 0, 1);
      add_cmd(MODE_JOIN, 5, 5, 5, 5, 1);
      add_cmd(MODE_CUT, 5, 5, 5, 5, 1);
      // unset handling
      add_cmd(MODE_PUSH, -1, -1, -1, -1, 0);
      add_cmd(MODE_CUT, 10, 20, 30, 40, 1);
      add_cmd(MODE_JOIN, 32767, -32768, 32767, -32768, 0);
      add_cmd(MODE_POP, 0, 0, 0, 0, 0);
      // extremes and wrapped widths
      add_cmd(MODE_PUSH, -32768, -32768, 32767, 32767, 1);
      add_cmd(MODE_JOIN, 32767, 32767, 32767, 32767, 1);
      add_cmd(MODE_PUSH, 32767, 32767, -32768, -32768, 1);
      add_cmd(MODE_CUT, 0, 0, 5, 5, 1);
      add_cmd(MODE_CUT, 100, 100, 1, 1, 1);
      add_cmd(MODE_PUSH, 0, 0, -1, -1, 1);
      add_cmd(MODE_CUT, -1, -1, 1, 1, 1);
      // fill to the top and overflow
      for (int i = 0; i < 5; i++) add_cmd(MODE_PUSH, -i, i, 10 + i, 20 - i, 1);
      add_cmd(MODE_PUSH, 1, 1, 1, 1, 1);
      add_cmd(MODE_PUSH, 2, 2, 2, 2, 1);
      for (int i = 0; i < 4; i++) add_cmd(MODE_POP, 0, 0, 0, 0, 1);

      for (int i = 0; i < RANDOM_CMDS; i++) add_random_cmd();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (cmds_taken != cmds_queued || tops_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && tops_due.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/crs_pkg.sv
rtl/core/crs_if.sv
rtl/core/crs_geom.sv
rtl/core/crs_store.sv
rtl/core/clip_rectangle_stack.sv
verif/tb.sv
